// File: rtl/ogi_pkg.sv
// Shared types and constants of the occupancy grid inflation core.
// Used by every module of the block; depends on nothing else.
`timescale 1ns / 1ps

package ogi_pkg;

    // Default sizes handed to the top level parameters.
    localparam int DEF_MAX_ROWS = 256;
    localparam int DEF_MAX_COLS = 256;
    localparam int DEF_MAX_PAD  = 7;

    // Coordinates carried between front and back. A window bound is at most
    // the largest input row or column plus the largest radius, so nine bits hold it.
    localparam int COORD_W = 9;

    // Depth of the queue between front and back.
    localparam int QUEUE_DEPTH = 2;

    // Cell codes.
    localparam logic [1:0] CODE_FREE = 2'd0;
    localparam logic [1:0] CODE_OCC  = 2'd1;
    localparam logic [1:0] CODE_UNK  = 2'd2;
    localparam logic [1:0] CODE_BAD  = 2'd3;

    // Command codes.
    localparam logic CMD_LOAD  = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    // Configuration register indexes and reset values.
    localparam logic [1:0] REG_GRID_WIDTH  = 2'd0;
    localparam logic [1:0] REG_GRID_HEIGHT = 2'd1;
    localparam logic [1:0] REG_PAD_RADIUS  = 2'd2;

    localparam logic [8:0] RST_GRID_WIDTH  = 9'd256;
    localparam logic [8:0] RST_GRID_HEIGHT = 9'd256;
    localparam logic [2:0] RST_PAD_RADIUS  = 3'd3;

    // One classified item as it waits in the queue.
    typedef struct packed {
        logic               is_query;
        logic               in_grid;
        logic [COORD_W-1:0] row;
        logic [COORD_W-1:0] col;
        logic [COORD_W-1:0] r0;
        logic [COORD_W-1:0] c0;
        logic [COORD_W-1:0] r1;
        logic [COORD_W-1:0] c1;
        logic [1:0]         load_code;
    } t_item;

endpackage

// File: rtl/ogi_front.sv
// Front part: configuration registers, item acceptance and classification.
// Depends on ogi_pkg for the item type, codes and reset values.
`timescale 1ns / 1ps

module ogi_front #(
    parameter int MAX_ROWS = ogi_pkg::DEF_MAX_ROWS,
    parameter int MAX_COLS = ogi_pkg::DEF_MAX_COLS,
    parameter int MAX_PAD  = ogi_pkg::DEF_MAX_PAD
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_valid,
    input  logic [1:0]        i_cfg_index,
    input  logic [8:0]        i_cfg_data,
    input  logic              i_accept,
    input  logic              i_command,
    input  logic [7:0]        i_row,
    input  logic [7:0]        i_col,
    input  logic [1:0]        i_cell_in,
    output logic              o_push,
    output ogi_pkg::t_item    o_item
);

    localparam int WW = $clog2(MAX_COLS + 1);
    localparam int HW = $clog2(MAX_ROWS + 1);
    localparam int PW = $clog2(MAX_PAD + 1);
    localparam int CW = ogi_pkg::COORD_W;

    logic [8:0] r_grid_width;
    logic [8:0] r_grid_height;
    logic [2:0] r_pad_radius;

    logic [WW-1:0] eff_w;
    logic [HW-1:0] eff_h;
    logic [PW-1:0] eff_p;
    logic [CW:0]   row_p;
    logic [CW:0]   col_p;

    // Configuration writes; an index beyond the list is dropped.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grid_width  <= ogi_pkg::RST_GRID_WIDTH;
            r_grid_height <= ogi_pkg::RST_GRID_HEIGHT;
            r_pad_radius  <= ogi_pkg::RST_PAD_RADIUS;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                ogi_pkg::REG_GRID_WIDTH:  r_grid_width  <= i_cfg_data;
                ogi_pkg::REG_GRID_HEIGHT: r_grid_height <= i_cfg_data;
                ogi_pkg::REG_PAD_RADIUS:  r_pad_radius  <= i_cfg_data[2:0];
                default: ;
            endcase
        end
    end

    // Grid size and radius clamped to their legal ranges.
    always_comb begin
        if (r_grid_width == 9'd0) begin
            eff_w = WW'(1);
        end else if (32'(r_grid_width) > MAX_COLS) begin
            eff_w = WW'(MAX_COLS);
        end else begin
            eff_w = WW'(r_grid_width);
        end
        if (r_grid_height == 9'd0) begin
            eff_h = HW'(1);
        end else if (32'(r_grid_height) > MAX_ROWS) begin
            eff_h = HW'(MAX_ROWS);
        end else begin
            eff_h = HW'(r_grid_height);
        end
        if (32'(r_pad_radius) > MAX_PAD) begin
            eff_p = PW'(MAX_PAD);
        end else begin
            eff_p = PW'(r_pad_radius);
        end
    end

    // Classification: range check and window bounds clipped to the grid.
    always_comb begin
        row_p = (CW + 1)'(i_row) + (CW + 1)'(eff_p);
        col_p = (CW + 1)'(i_col) + (CW + 1)'(eff_p);

        o_item.is_query = (i_command == ogi_pkg::CMD_QUERY);
        o_item.in_grid  = (32'(i_row) < 32'(eff_h)) && (32'(i_col) < 32'(eff_w));
        o_item.row      = CW'(i_row);
        o_item.col      = CW'(i_col);

        if ((CW + 1)'(i_row) >= (CW + 1)'(eff_p)) begin
            o_item.r0 = CW'(row_p - (CW + 1)'(eff_p) - (CW + 1)'(eff_p));
        end else begin
            o_item.r0 = '0;
        end
        if ((CW + 1)'(i_col) >= (CW + 1)'(eff_p)) begin
            o_item.c0 = CW'(col_p - (CW + 1)'(eff_p) - (CW + 1)'(eff_p));
        end else begin
            o_item.c0 = '0;
        end

        // The clip value is only taken when it lies below row plus radius.
        if (32'(row_p) >= 32'(eff_h)) begin
            o_item.r1 = CW'(32'(eff_h) - 1);
        end else begin
            o_item.r1 = CW'(row_p);
        end
        if (32'(col_p) >= 32'(eff_w)) begin
            o_item.c1 = CW'(32'(eff_w) - 1);
        end else begin
            o_item.c1 = CW'(col_p);
        end

        // The unused cell code is stored as unknown.
        o_item.load_code = (i_cell_in == ogi_pkg::CODE_BAD) ? ogi_pkg::CODE_UNK : i_cell_in;
    end

    assign o_push = i_accept;

endmodule

// File: rtl/ogi_queue.sv
// Short queue of classified items between front and back.
// Depends on ogi_pkg for the item type and the queue depth.
`timescale 1ns / 1ps

module ogi_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  ogi_pkg::t_item    i_item,
    input  logic              i_pop,
    output ogi_pkg::t_item    o_item,
    output logic              o_empty,
    output logic              o_full
);

    localparam int DEPTH = ogi_pkg::QUEUE_DEPTH;
    localparam int PTRW  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNTW  = $clog2(DEPTH + 1);

    ogi_pkg::t_item r_slot [DEPTH];
    logic [PTRW-1:0] r_wr_ptr;
    logic [PTRW-1:0] r_rd_ptr;
    logic [CNTW-1:0] r_count;
    logic [PTRW-1:0] n_wr_ptr;
    logic [PTRW-1:0] n_rd_ptr;

    // Pointers wrap at the depth.
    always_comb begin
        n_wr_ptr = (32'(r_wr_ptr) == DEPTH - 1) ? '0 : r_wr_ptr + PTRW'(1);
        n_rd_ptr = (32'(r_rd_ptr) == DEPTH - 1) ? '0 : r_rd_ptr + PTRW'(1);
    end

    assign o_empty = (r_count == '0);
    assign o_full  = (32'(r_count) == DEPTH);
    assign o_item  = r_slot[r_rd_ptr];

    // Storage of the waiting items.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr_ptr] <= i_item;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= n_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= n_rd_ptr;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + CNTW'(1);
            end else if (!i_push && i_pop) begin
                r_count <= r_count - CNTW'(1);
            end
        end
    end

endmodule

// File: rtl/ogi_back.sv
// Back part: the grid memory and the sequencer that stores loads and scans
// query windows. Depends on ogi_pkg for the item type and cell codes.
`timescale 1ns / 1ps

module ogi_back #(
    parameter int MAX_ROWS = ogi_pkg::DEF_MAX_ROWS,
    parameter int MAX_COLS = ogi_pkg::DEF_MAX_COLS
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  ogi_pkg::t_item    i_item,
    input  logic              i_empty,
    output logic              o_pop,
    output logic              o_result_valid,
    output logic [1:0]        o_cell_out,
    output logic              o_out_of_range
);

    localparam int DEPTH = MAX_ROWS * MAX_COLS;
    localparam int AW    = $clog2(DEPTH);
    localparam int CW    = ogi_pkg::COORD_W;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_CENTER,
        S_RESULT
    } t_state;

    t_state r_state;
    ogi_pkg::t_item r_item;
    logic [CW-1:0] r_i;
    logic [CW-1:0] r_j;
    logic r_hit;
    logic r_rd_vld;
    logic [1:0] r_rdata;
    logic [1:0] r_mem [DEPTH];

    logic [AW-1:0] rd_addr;
    logic [AW-1:0] wr_addr;
    logic wr_en;

    // Row-major address of a cell.
    function automatic logic [AW-1:0] cell_addr(input logic [CW-1:0] row,
                                                input logic [CW-1:0] col);
        cell_addr = AW'(AW'(row) * AW'(MAX_COLS)) + AW'(col);
    endfunction

    assign o_pop   = (r_state == S_IDLE) && !i_empty;
    assign wr_en   = o_pop && !i_item.is_query && i_item.in_grid;
    assign wr_addr = cell_addr(i_item.row, i_item.col);
    assign rd_addr = (r_state == S_SCAN) ? cell_addr(r_i, r_j)
                                         : cell_addr(r_item.row, r_item.col);

    // Grid memory with one write port and one registered read port.
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= i_item.load_code;
        end
        r_rdata <= r_mem[rd_addr];
    end

    // Sequencer: one window cell read per cycle, then the center cell.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_IDLE;
            r_rd_vld       <= 1'b0;
            r_hit          <= 1'b0;
            o_result_valid <= 1'b0;
            o_cell_out     <= ogi_pkg::CODE_FREE;
            o_out_of_range <= 1'b0;
        end else begin
            o_result_valid <= 1'b0;
            r_rd_vld       <= 1'b0;
            if (r_rd_vld && (r_rdata == ogi_pkg::CODE_OCC)) begin
                r_hit <= 1'b1;
            end
            case (r_state)
                S_IDLE: begin
                    if (o_pop) begin
                        r_item <= i_item;
                        r_i    <= i_item.r0;
                        r_j    <= i_item.c0;
                        r_hit  <= 1'b0;
                        if (i_item.is_query && !i_item.in_grid) begin
                            o_result_valid <= 1'b1;
                            o_cell_out     <= ogi_pkg::CODE_FREE;
                            o_out_of_range <= 1'b1;
                        end else if (i_item.is_query) begin
                            r_state <= S_SCAN;
                        end
                    end
                end
                S_SCAN: begin
                    r_rd_vld <= 1'b1;
                    if (r_j == r_item.c1) begin
                        r_j <= r_item.c0;
                        if (r_i == r_item.r1) begin
                            r_state <= S_CENTER;
                        end else begin
                            r_i <= r_i + CW'(1);
                        end
                    end else begin
                        r_j <= r_j + CW'(1);
                    end
                end
                S_CENTER: begin
                    // The last window cell is checked while the center is read.
                    r_state <= S_RESULT;
                end
                S_RESULT: begin
                    o_result_valid <= 1'b1;
                    o_cell_out     <= r_hit ? ogi_pkg::CODE_OCC : r_rdata;
                    o_out_of_range <= 1'b0;
                    r_state        <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

// File: rtl/occupancy_grid_inflation_core.sv
// Top level of the occupancy grid inflation core.
// Instantiates ogi_front, ogi_queue and ogi_back; depends on ogi_pkg.
`timescale 1ns / 1ps

// A load item is written to the grid memory as it leaves the queue and gives
// no result. A query inside the grid reads its clipped window from the single
// grid memory read port, one cell per cycle, then the center cell; the back
// part takes no new item until it has given that query's result. A query
// outside the grid gives its result without a scan. Up to two items wait in a
// queue, so start is taken while a query is being scanned; busy is high only
// when that queue is full. Each result shows on o_result_valid for exactly one
// cycle and must be taken then: the receiver cannot stall the block.
// Configuration writes are taken in every cycle and must only be made while
// the block is idle. Cells must be loaded before a query window covers them.
module occupancy_grid_inflation_core #(
    parameter int MAX_ROWS = ogi_pkg::DEF_MAX_ROWS,
    parameter int MAX_COLS = ogi_pkg::DEF_MAX_COLS,
    parameter int MAX_PAD  = ogi_pkg::DEF_MAX_PAD
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic [1:0] i_cfg_index,
    input  logic [8:0] i_cfg_data,
    input  logic       start,
    output logic       busy,
    input  logic       i_command,
    input  logic [7:0] i_row,
    input  logic [7:0] i_col,
    input  logic [1:0] i_cell_in,
    output logic       o_result_valid,
    output logic [1:0] o_cell_out,
    output logic       o_out_of_range
);

    ogi_pkg::t_item front_item;
    ogi_pkg::t_item head_item;
    logic push;
    logic pop;
    logic empty;
    logic full;

    assign o_cfg_ready = 1'b1;
    assign busy        = full;

    // Acceptance and classification.
    ogi_front #(
        .MAX_ROWS (MAX_ROWS),
        .MAX_COLS (MAX_COLS),
        .MAX_PAD  (MAX_PAD)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid && o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_accept    (start && !busy),
        .i_command   (i_command),
        .i_row       (i_row),
        .i_col       (i_col),
        .i_cell_in   (i_cell_in),
        .o_push      (push),
        .o_item      (front_item)
    );

    // Items waiting for the back part.
    ogi_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (front_item),
        .i_pop   (pop),
        .o_item  (head_item),
        .o_empty (empty),
        .o_full  (full)
    );

    // Grid memory and window scan.
    ogi_back #(
        .MAX_ROWS (MAX_ROWS),
        .MAX_COLS (MAX_COLS)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_item         (head_item),
        .i_empty        (empty),
        .o_pop          (pop),
        .o_result_valid (o_result_valid),
        .o_cell_out     (o_cell_out),
        .o_out_of_range (o_out_of_range)
    );

endmodule

// File: sim/tb_top.sv
// Self-checking testbench for occupancy_grid_inflation_core: loads cells, queries
// inflated cells and checks every result against its own grid predictor or a table value.
// Depends on ogi_pkg and the core RTL only.
`timescale 1ns / 1ps

module tb_top;

    localparam int MAX_ROWS   = ogi_pkg::DEF_MAX_ROWS;
    localparam int MAX_COLS   = ogi_pkg::DEF_MAX_COLS;
    localparam int MAX_PAD    = ogi_pkg::DEF_MAX_PAD;
    localparam int GRID_CELLS = MAX_ROWS * MAX_COLS;
    localparam int RAND_ITEMS = 1050;
    localparam int DIR_LEN    = 27;
    localparam int FOCUS_SPAN = 8;
    localparam int IDLE_PCT   = 11;

    // Register index past the end of the list; the core must ignore it.
    localparam logic [1:0] REG_NONE = 2'd3;

    // One result as the core should return it.
    typedef struct packed {
        logic [1:0] cell_state;
        logic       off_grid;
    } t_inflated;

    // One row of the directed table: a register write or an item.
    typedef struct packed {
        logic       is_cfg;
        logic [1:0] cfg_idx;
        logic [8:0] cfg_data;
        logic       cmd;
        logic [7:0] row;
        logic [7:0] col;
        logic [1:0] cell_in;
        logic       typed;
        t_inflated  want;
    } t_vector;

    logic       i_clk          = 1'b0;
    logic       i_rst_n        = 1'b0;
    logic       i_cfg_valid    = 1'b0;
    logic [1:0] i_cfg_index    = '0;
    logic [8:0] i_cfg_data     = '0;
    logic       start          = 1'b0;
    logic       i_command      = ogi_pkg::CMD_LOAD;
    logic [7:0] i_row          = '0;
    logic [7:0] i_col          = '0;
    logic [1:0] i_cell_in      = ogi_pkg::CODE_FREE;
    logic       o_cfg_ready;
    logic       busy;
    logic       o_result_valid;
    logic [1:0] o_cell_out;
    logic       o_out_of_range;

    // Predictor state: the grid, which cells hold a known value, and the registers.
    logic [1:0] model_grid [0:GRID_CELLS-1];
    bit         loaded_map [0:GRID_CELLS-1];
    logic [8:0] cfg_width  = ogi_pkg::RST_GRID_WIDTH;
    logic [8:0] cfg_height = ogi_pkg::RST_GRID_HEIGHT;
    logic [2:0] cfg_pad    = ogi_pkg::RST_PAD_RADIUS;

    t_inflated  expected_cells [$];
    t_vector    dir_tab [0:DIR_LEN-1];

    int occ_pct    = 3;
    bit burst_mode = 1'b0;
    int item_cnt, load_cnt, query_cnt, off_grid_cnt, setting_cnt;
    int result_cnt, occ_result_cnt, fail_cnt;

    occupancy_grid_inflation_core u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .start          (start),
        .busy           (busy),
        .i_command      (i_command),
        .i_row          (i_row),
        .i_col          (i_col),
        .i_cell_in      (i_cell_in),
        .o_result_valid (o_result_valid),
        .o_cell_out     (o_cell_out),
        .o_out_of_range (o_out_of_range)
    );

    always #4 i_clk = ~i_clk;

    // Size registers read as zero become one and saturate at the grid maximum.
    function automatic int eff_size(logic [8:0] v, int lim);
        int x;
        x = v;
        if (x < 1) return 1;
        if (x > lim) return lim;
        return x;
    endfunction

    function automatic int grid_w();
        return eff_size(cfg_width, MAX_COLS);
    endfunction

    function automatic int grid_h();
        return eff_size(cfg_height, MAX_ROWS);
    endfunction

    // Square window around a cell, clipped to zero and to the last row or column.
    function automatic void window_bounds(input int row, input int col,
                                          output int r0, output int c0,
                                          output int r1, output int c1);
        int p;
        p  = (int'(cfg_pad) > MAX_PAD) ? MAX_PAD : int'(cfg_pad);
        r0 = (row >= p) ? row - p : 0;
        c0 = (col >= p) ? col - p : 0;
        r1 = (row + p >= grid_h()) ? grid_h() - 1 : row + p;
        c1 = (col + p >= grid_w()) ? grid_w() - 1 : col + p;
    endfunction

    // Applies one item to the predicted grid; returns 1 when the item gives a result.
    function automatic bit inflate_step(logic cmd, logic [7:0] row, logic [7:0] col,
                                        logic [1:0] v, output t_inflated res);
        int r0, c0, r1, c1;
        bit in_grid, hit;
        in_grid = (int'(row) < grid_h()) && (int'(col) < grid_w());
        res = '0;
        if (cmd == ogi_pkg::CMD_LOAD) begin
            if (in_grid) begin
                model_grid[row * MAX_COLS + col] =
                    (v == ogi_pkg::CODE_BAD) ? ogi_pkg::CODE_UNK : v;
                loaded_map[row * MAX_COLS + col] = 1'b1;
            end
            return 1'b0;
        end
        if (!in_grid) begin
            res.cell_state = ogi_pkg::CODE_FREE;
            res.off_grid   = 1'b1;
            return 1'b1;
        end
        window_bounds(row, col, r0, c0, r1, c1);
        hit = 1'b0;
        for (int i = r0; i <= r1; i++)
            for (int j = c0; j <= c1; j++)
                if (model_grid[i * MAX_COLS + j] == ogi_pkg::CODE_OCC) hit = 1'b1;
        res.cell_state = hit ? ogi_pkg::CODE_OCC : model_grid[row * MAX_COLS + col];
        return 1'b1;
    endfunction

    // Random cell value; occupied cells stay sparse so that not every window hits one.
    function automatic logic [1:0] rand_cell();
        int k;
        k = $urandom_range(99);
        if (k < occ_pct) return ogi_pkg::CODE_OCC;
        if (k < 70) return ogi_pkg::CODE_FREE;
        if (k < 90) return ogi_pkg::CODE_UNK;
        return ogi_pkg::CODE_BAD;
    endfunction

    // Random size register value, biased toward small grids and the extremes.
    function automatic logic [8:0] pick_size();
        int k;
        k = $urandom_range(99);
        if (k < 8) return 9'd0;
        if (k < 14) return 9'd256;
        if (k < 20) return 9'($urandom_range(511, 257));
        if (k < 26) return 9'd1;
        if (k < 36) return 9'($urandom_range(256, 25));
        return 9'($urandom_range(24, 2));
    endfunction

    // Corner of the region that one setting's items stay in.
    function automatic int pick_base(int extent, int span);
        int k;
        k = $urandom_range(2);
        if (k == 0) return 0;
        if (k == 1) return extent - span;
        return $urandom_range(extent - span);
    endfunction

    // Directed table rows: load, query checked by the predictor, query with a fixed
    // result, and register write.
    function automatic t_vector ld(int row, int col, logic [1:0] v);
        t_vector t;
        t = '0;
        t.cmd = ogi_pkg::CMD_LOAD;
        t.row = 8'(row);
        t.col = 8'(col);
        t.cell_in = v;
        return t;
    endfunction

    function automatic t_vector qy(int row, int col);
        t_vector t;
        t = '0;
        t.cmd = ogi_pkg::CMD_QUERY;
        t.row = 8'(row);
        t.col = 8'(col);
        t.cell_in = ogi_pkg::CODE_BAD;
        return t;
    endfunction

    function automatic t_vector qt(int row, int col, logic [1:0] v, logic off);
        t_vector t;
        t = qy(row, col);
        t.typed = 1'b1;
        t.want.cell_state = v;
        t.want.off_grid = off;
        return t;
    endfunction

    function automatic t_vector cw(logic [1:0] idx, int data);
        t_vector t;
        t = '0;
        t.is_cfg = 1'b1;
        t.cfg_idx = idx;
        t.cfg_data = 9'(data);
        return t;
    endfunction

    // Presents one item, waits until it is taken and records what it should give.
    task automatic issue(logic cmd, logic [7:0] row, logic [7:0] col, logic [1:0] v,
                         bit typed, t_inflated want);
        t_inflated res;
        while (!burst_mode && $urandom_range(99) < IDLE_PCT) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start     <= 1'b1;
        i_command <= cmd;
        i_row     <= row;
        i_col     <= col;
        i_cell_in <= v;
        do @(posedge i_clk); while (busy);
        item_cnt++;
        if (inflate_step(cmd, row, col, v, res)) begin
            expected_cells.push_back(typed ? want : res);
            query_cnt++;
            if (res.off_grid) off_grid_cnt++;
        end else begin
            load_cnt++;
        end
    endtask

    // Loads every cell of a query window that holds no known value yet.
    task automatic cover_window(logic [7:0] row, logic [7:0] col, bit rand_fill);
        int r0, c0, r1, c1;
        window_bounds(row, col, r0, c0, r1, c1);
        for (int i = r0; i <= r1; i++)
            for (int j = c0; j <= c1; j++)
                if (!loaded_map[i * MAX_COLS + j])
                    issue(ogi_pkg::CMD_LOAD, 8'(i), 8'(j),
                          rand_fill ? rand_cell() : ogi_pkg::CODE_FREE, 1'b0, '0);
    endtask

    // Waits until the core has nothing left to do; trailing loads give no result.
    task automatic settle();
        start <= 1'b0;
        while (expected_cells.size() != 0) @(posedge i_clk);
        repeat (16) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [8:0] data);
        while ($urandom_range(99) < IDLE_PCT) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        case (idx)
            ogi_pkg::REG_GRID_WIDTH:  cfg_width  = data;
            ogi_pkg::REG_GRID_HEIGHT: cfg_height = data;
            ogi_pkg::REG_PAD_RADIUS:  cfg_pad    = data[2:0];
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    // Compare each result with the oldest expectation.
    always @(posedge i_clk) begin
        t_inflated want;
        if (i_rst_n && o_result_valid) begin
            if (expected_cells.size() == 0) begin
                $error("unexpected result: cell_out=%0d out_of_range=%0d",
                       o_cell_out, o_out_of_range);
                fail_cnt++;
            end else begin
                want = expected_cells.pop_front();
                result_cnt++;
                if (o_cell_out == ogi_pkg::CODE_OCC) occ_result_cnt++;
                if (o_cell_out !== want.cell_state) begin
                    $error("cell_out: expected %0d, got %0d", want.cell_state, o_cell_out);
                    fail_cnt++;
                end
                if (o_out_of_range !== want.off_grid) begin
                    $error("out_of_range: expected %0d, got %0d", want.off_grid,
                           o_out_of_range);
                    fail_cnt++;
                end
            end
        end
    end

    // Main sequence: reset, directed table, random settings, drain.
    initial begin
        int h, w, span_r, span_c, base_r, base_c, k, n, rand_start;
        logic [7:0] row, col;

        dir_tab = '{
            // Reset setting: full grid, radius three; clamps at both ends.
            ld(0, 0, ogi_pkg::CODE_OCC), ld(0, 5, ogi_pkg::CODE_FREE),
            qt(0, 0, ogi_pkg::CODE_OCC, 1'b0),
            ld(255, 255, ogi_pkg::CODE_UNK), qt(255, 255, ogi_pkg::CODE_UNK, 1'b0),
            // The unused code three is stored as unknown.
            ld(255, 0, ogi_pkg::CODE_BAD), qt(255, 0, ogi_pkg::CODE_UNK, 1'b0),
            // Occupied cell exactly at the window corner, then just outside it.
            ld(3, 4, ogi_pkg::CODE_OCC), qy(6, 7), qy(7, 8),
            // Width zero reads as one, oversize height saturates, radius bits above
            // the register are dropped, and the spare index is ignored.
            cw(ogi_pkg::REG_GRID_WIDTH, 0), cw(ogi_pkg::REG_GRID_HEIGHT, 300),
            cw(ogi_pkg::REG_PAD_RADIUS, 9'h1F8), cw(REG_NONE, 5),
            qt(0, 1, ogi_pkg::CODE_FREE, 1'b1),
            ld(0, 5, ogi_pkg::CODE_OCC), qy(255, 0), qy(0, 0),
            // Two rows, widest grid, largest radius.
            cw(ogi_pkg::REG_GRID_WIDTH, 511), cw(ogi_pkg::REG_GRID_HEIGHT, 2),
            cw(ogi_pkg::REG_PAD_RADIUS, 7),
            qt(2, 0, ogi_pkg::CODE_FREE, 1'b1),
            qy(1, 10), qy(1, 255), ld(1, 254, ogi_pkg::CODE_OCC), qy(0, 248),
            qt(255, 255, ogi_pkg::CODE_FREE, 1'b1)
        };

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_tab[i]) begin
            if (dir_tab[i].is_cfg) begin
                settle();
                write_reg(dir_tab[i].cfg_idx, dir_tab[i].cfg_data);
            end else begin
                if (dir_tab[i].cmd == ogi_pkg::CMD_QUERY && int'(dir_tab[i].row) < grid_h()
                        && int'(dir_tab[i].col) < grid_w())
                    cover_window(dir_tab[i].row, dir_tab[i].col, 1'b0);
                issue(dir_tab[i].cmd, dir_tab[i].row, dir_tab[i].col, dir_tab[i].cell_in,
                      dir_tab[i].typed, dir_tab[i].want);
            end
        end

        // Random part: one grid setting per pass, items kept inside a small region.
        rand_start = item_cnt;
        while (item_cnt - rand_start < RAND_ITEMS) begin
            settle();
            write_reg(ogi_pkg::REG_GRID_WIDTH, pick_size());
            write_reg(ogi_pkg::REG_GRID_HEIGHT, pick_size());
            write_reg(ogi_pkg::REG_PAD_RADIUS, 9'($urandom_range(511)));
            if ($urandom_range(99) < 15) write_reg(REG_NONE, 9'($urandom_range(511)));
            setting_cnt++;
            burst_mode = (setting_cnt == 4);
            k = $urandom_range(3);
            occ_pct = (k == 0) ? 1 : (k == 1) ? 2 : (k == 2) ? 5 : 12;
            h = grid_h();
            w = grid_w();
            span_r = (h < FOCUS_SPAN) ? h : FOCUS_SPAN;
            span_c = (w < FOCUS_SPAN) ? w : FOCUS_SPAN;
            base_r = pick_base(h, span_r);
            base_c = pick_base(w, span_c);
            n = $urandom_range(120, 60);
            repeat (n) begin
                k = $urandom_range(99);
                if (k < 10 && (h < MAX_ROWS || w < MAX_COLS)) begin
                    // Off-grid load or query.
                    if (h < MAX_ROWS && (w == MAX_COLS || $urandom_range(1))) begin
                        row = 8'($urandom_range(255, h));
                        col = 8'($urandom_range(255));
                    end else begin
                        row = 8'($urandom_range(255));
                        col = 8'($urandom_range(255, w));
                    end
                    issue(1'($urandom_range(1)), row, col, 2'($urandom_range(3)), 1'b0, '0);
                end else begin
                    row = 8'(base_r + $urandom_range(span_r - 1));
                    col = 8'(base_c + $urandom_range(span_c - 1));
                    if (k < 45) begin
                        issue(ogi_pkg::CMD_LOAD, row, col, rand_cell(), 1'b0, '0);
                    end else begin
                        cover_window(row, col, 1'b1);
                        issue(ogi_pkg::CMD_QUERY, row, col, 2'($urandom_range(3)),
                              1'b0, '0);
                    end
                end
            end
        end
        burst_mode = 1'b0;
        start <= 1'b0;

        // Drain, then allow one full window scan for any stray result.
        while (expected_cells.size() != 0) @(posedge i_clk);
        repeat (300) @(posedge i_clk);

        $display("Run covered %0d items (%0d loads, %0d queries, %0d off the grid) over %0d",
                 item_cnt, load_cnt, query_cnt, off_grid_cnt, setting_cnt + 3);
        $display("grid settings; %0d results checked, %0d of them occupied.",
                 result_cnt, occ_result_cnt);
        if (fail_cnt == 0 && expected_cells.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    // Run limit, far beyond the slowest correct run.
    initial begin
        #15ms;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
